// ===== rtl/chw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Chebyshev waveshaper package
// Shared types, register indexes, formats and the saturation helper.
// ----------------------------------------------------------------------------
package chw_pkg;

	localparam int SAMPLE_W = 16;
	localparam int TERM0_W  = 17;
	localparam int PROD_W   = 32;
	localparam int ACC_W    = 35;
	localparam int WIDE_W   = 20;
	localparam int ORD_W    = 3;
	localparam int IDX_W    = 3;
	localparam int NUM_COEFS = 4;

	localparam logic [IDX_W-1:0] REG_POLY_ORDER = 3'd0;
	localparam logic [IDX_W-1:0] REG_COEF_1     = 3'd1;
	localparam logic [IDX_W-1:0] REG_COEF_2     = 3'd2;
	localparam logic [IDX_W-1:0] REG_COEF_3     = 3'd3;
	localparam logic [IDX_W-1:0] REG_COEF_4     = 3'd4;

	localparam logic [ORD_W-1:0] ORDER_RESET = 3'd4;
	localparam logic signed [SAMPLE_W-1:0] COEF_1_RESET = 16'sd4096;
	localparam logic signed [TERM0_W-1:0]  T0_ONE       = 17'sd32768;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] x;
		logic signed [SAMPLE_W-1:0] t1;
		logic signed [TERM0_W-1:0]  t2;
		logic signed [ACC_W-1:0]    acc;
	} stage_t;

	function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [WIDE_W-1:0] v);
		logic signed [SAMPLE_W-1:0] r;
		if (v > 20'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -20'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[SAMPLE_W-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/chebyshev_waveshaper_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Chebyshev waveshaper top level
// Shapes each Q1.15 sample into a weighted sum of Chebyshev terms T1..Tn.
//
// Input requests arrive on in_valid/in_ready with sample_in; results leave on
// out_valid/out_ready with sample_out in Q4.12. Each request gives one result.
// Registers are written on cfg_valid/cfg_ready with cfg_index and cfg_data:
// index 0 is the order, indexes 1 to 4 the term weights; others are ignored.
// cfg_ready is always high. Write registers only while the block is empty.
// A request runs through MAX_ORDER cells and the output register, the first
// cell loading at acceptance. One request is taken every cycle while the
// receiver takes results; each cell holds one multiplier pair and one
// register stage.
// Reset empties the pipeline, sets the order to 4 and the weights to unit
// gain on T1 only. When the receiver stalls, requests keep entering until
// every stage holds one, then in_ready falls.
// ----------------------------------------------------------------------------
module chebyshev_waveshaper_top
	import chw_pkg::*;
#(
	parameter int MAX_ORDER = 4
)
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic signed [SAMPLE_W-1:0] sample_in,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic signed [SAMPLE_W-1:0]      sample_out,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [IDX_W-1:0]           cfg_index,
	input  wire logic [SAMPLE_W-1:0]        cfg_data
);

	logic [ORD_W-1:0]                    poly_order_q;
	logic [NUM_COEFS-1:0][SAMPLE_W-1:0]  coef_q;
	logic [ORD_W-1:0]                    order_eff;

	stage_t                              chain_data  [MAX_ORDER+1];
	logic   [MAX_ORDER:0]                chain_valid;
	logic   [MAX_ORDER:0]                chain_ready;
	logic signed [SAMPLE_W-1:0]          weight      [MAX_ORDER];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_order_q <= ORDER_RESET;
			coef_q       <= {{((NUM_COEFS-1)*SAMPLE_W){1'b0}}, COEF_1_RESET};
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_POLY_ORDER: poly_order_q <= cfg_data[ORD_W-1:0];
				REG_COEF_1:     coef_q[0]    <= cfg_data;
				REG_COEF_2:     coef_q[1]    <= cfg_data;
				REG_COEF_3:     coef_q[2]    <= cfg_data;
				REG_COEF_4:     coef_q[3]    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (poly_order_q == '0) begin
			order_eff = ORD_W'(1);
		end else if (poly_order_q > ORD_W'(MAX_ORDER)) begin
			order_eff = ORD_W'(MAX_ORDER);
		end else begin
			order_eff = poly_order_q;
		end
	end

	assign chain_valid[0]    = in_valid;
	assign in_ready          = chain_ready[0];
	assign chain_data[0].x   = sample_in;
	assign chain_data[0].t1  = sample_in;
	assign chain_data[0].t2  = T0_ONE;
	assign chain_data[0].acc = '0;

	for (genvar k = 0; k < MAX_ORDER; k++) begin : g_cell
		if (k < NUM_COEFS) begin : g_wt
			assign weight[k] = (ORD_W'(k + 1) <= order_eff) ? $signed(coef_q[k]) : '0;
		end else begin : g_zero
			assign weight[k] = '0;
		end

		chw_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[k]),
			.in_ready  (chain_ready[k]),
			.in_data   (chain_data[k]),
			.weight    (weight[k]),
			.out_valid (chain_valid[k+1]),
			.out_ready (chain_ready[k+1]),
			.out_data  (chain_data[k+1])
		);
	end

	chw_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (chain_valid[MAX_ORDER]),
		.in_ready  (chain_ready[MAX_ORDER]),
		.in_data   (chain_data[MAX_ORDER]),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sample    (sample_out)
	);

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while the output register is empty");

	a_result_from_chain: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(chain_valid[MAX_ORDER]))
		else $error("result appeared without a request in the last cell");

	a_bad_index_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && (cfg_index > REG_COEF_4) |=> $stable(poly_order_q) && $stable(coef_q))
		else $error("register changed on a write to an unknown index");

endmodule
`default_nettype wire

// ===== rtl/chw_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Chebyshev waveshaper cell
// Adds one weighted term to the running sum and forms the next polynomial
// term with the recurrence, then hands the request to its neighbor.
// ----------------------------------------------------------------------------
module chw_cell
	import chw_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire stage_t                     in_data,
	input  wire logic signed [SAMPLE_W-1:0] weight,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output stage_t                          out_data
);

	logic                       valid_q;
	stage_t                     data_q;
	logic signed [PROD_W-1:0]   rec_prod;
	logic signed [PROD_W-1:0]   rec_rnd;
	logic signed [WIDE_W-1:0]   rec_diff;
	logic signed [PROD_W-1:0]   term_prod;
	stage_t                     next_data;

	always_comb begin
		rec_prod  = in_data.x * in_data.t1;
		rec_rnd   = rec_prod + 32'sd8192;
		rec_diff  = WIDE_W'($signed(rec_rnd[PROD_W-1:14])) - WIDE_W'(in_data.t2);
		term_prod = weight * in_data.t1;
		next_data.x   = in_data.x;
		next_data.t1  = sat16(rec_diff);
		next_data.t2  = TERM0_W'(in_data.t1);
		next_data.acc = in_data.acc + ACC_W'(term_prod);
	end

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q <= next_data;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/chw_out.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Chebyshev waveshaper output stage
// Rounds the exact sum to Q4.12, saturates it and holds it for the receiver.
// ----------------------------------------------------------------------------
module chw_out
	import chw_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire stage_t                     in_data,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic signed [SAMPLE_W-1:0]      sample
);

	logic                       valid_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic signed [ACC_W-1:0]    rnd_sum;

	assign rnd_sum   = in_data.acc + 35'sd16384;
	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign sample    = sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_q <= sat16(rnd_sum[ACC_W-1:15]);
		end
	end

endmodule
`default_nettype wire
